/* src/bcd_pkg.sv */
// ---------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the button chord detector.
// ---------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

  localparam int NUM_PADS       = 8;
  localparam int PAD_BITS       = 3;
  localparam int TIME_BITS      = 32;
  localparam int BTN_BITS       = 32;
  localparam int TIMEOUT_BITS   = 16;
  localparam int BIT_IDX_BITS   = 5;
  localparam int IN_TDATA_BITS  = 72;
  localparam int OUT_TDATA_BITS = 72;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET  = 16'd500;
  localparam logic [BIT_IDX_BITS-1:0] VIEW_BIT_RESET = 5'd1;
  localparam logic [BIT_IDX_BITS-1:0] MENU_BIT_RESET = 5'd0;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_VIEW_WAIT = 2'd1,
    MODE_MENU_WAIT = 2'd2,
    MODE_CHORD     = 2'd3
  } pad_mode_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_VIEW_BIT = 2'd1,
    CFG_MENU_BIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_RESET = 1'b1
  } opcode_t;

  typedef struct packed {
    pad_mode_t              mode;
    logic                   prev_view;
    logic                   prev_menu;
    logic [TIME_BITS-1:0]   start_ms;
  } pad_state_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [PAD_BITS-1:0]    pad_index;
    logic                   pad_present;
    logic [BTN_BITS-1:0]    buttons;
    logic [TIME_BITS-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic [TIMEOUT_BITS-1:0] timeout_ms;
    logic [BIT_IDX_BITS-1:0] view_bit;
    logic [BIT_IDX_BITS-1:0] menu_bit;
  } cfg_t;

  typedef struct packed {
    logic                   chord_fired;
    logic [BTN_BITS-1:0]    raw_buttons;
    logic [BTN_BITS-1:0]    masked_buttons;
  } result_t;

  typedef struct packed {
    logic                   en;
    logic [PAD_BITS-1:0]    pad;
    pad_state_t             state;
  } wb_t;

endpackage

`default_nettype wire

/* src/bcd_state_mem.sv */
// ---------------------------------------------------------------------------
// bcd_state_mem
// Per-pad state memory with a registered read, entry valid bits and
// forwarding of a write that lands in the same cycle as a read.
// ---------------------------------------------------------------------------
`default_nettype none

module bcd_state_mem (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          rd_en,
  input  wire [bcd_pkg::PAD_BITS-1:0]  rd_addr,
  output bcd_pkg::pad_state_t          rd_state,
  input  wire bcd_pkg::wb_t            wb
);

  bcd_pkg::pad_state_t               mem_r [bcd_pkg::NUM_PADS];
  bcd_pkg::pad_state_t               mem_q_r;
  bcd_pkg::pad_state_t               byp_r;
  logic [bcd_pkg::NUM_PADS-1:0]      valid_r;
  logic                              hit_r;
  logic                              entry_valid_r;
  logic                              same_addr;

  assign same_addr = wb.en && (wb.pad == rd_addr);

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem_r[wb.pad] <= wb.state;
    end
    if (rd_en) begin
      mem_q_r <= mem_r[rd_addr];
      byp_r   <= wb.state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      hit_r         <= 1'b0;
      entry_valid_r <= 1'b0;
    end else begin
      if (wb.en) begin
        valid_r[wb.pad] <= 1'b1;
      end
      if (rd_en) begin
        hit_r         <= same_addr;
        entry_valid_r <= valid_r[rd_addr];
      end
    end
  end

  always_comb begin
    if (hit_r) begin
      rd_state = byp_r;
    end else if (entry_valid_r) begin
      rd_state = mem_q_r;
    end else begin
      rd_state = '0;
    end
  end

endmodule

`default_nettype wire

/* src/bcd_pad_fsm.sv */
// ---------------------------------------------------------------------------
// bcd_pad_fsm
// Next-state and output logic of one pad's chord state machine.
// ---------------------------------------------------------------------------
`default_nettype none

module bcd_pad_fsm (
  input  wire bcd_pkg::item_t       item,
  input  wire bcd_pkg::pad_state_t  cur,
  input  wire bcd_pkg::cfg_t        cfg,
  output bcd_pkg::result_t          res,
  output bcd_pkg::wb_t              wb
);

  logic [bcd_pkg::BTN_BITS-1:0]  vbit;
  logic [bcd_pkg::BTN_BITS-1:0]  mbit;
  logic [bcd_pkg::BTN_BITS-1:0]  btn;
  logic [bcd_pkg::BTN_BITS-1:0]  masked;
  logic [bcd_pkg::TIME_BITS-1:0] elapsed;
  logic                          v;
  logic                          m;
  logic                          timed_out;
  logic                          in_range;
  logic                          fired;
  bcd_pkg::pad_state_t           nxt;

  assign btn       = item.buttons;
  assign vbit      = bcd_pkg::BTN_BITS'(1) << cfg.view_bit;
  assign mbit      = bcd_pkg::BTN_BITS'(1) << cfg.menu_bit;
  assign v         = |(btn & vbit);
  assign m         = |(btn & mbit);
  assign elapsed   = item.now_ms - cur.start_ms;
  assign timed_out = elapsed > bcd_pkg::TIME_BITS'(cfg.timeout_ms);
  assign in_range  = {1'b0, item.pad_index} < (bcd_pkg::PAD_BITS + 1)'(bcd_pkg::NUM_PADS);

  always_comb begin
    nxt    = cur;
    masked = btn;
    fired  = 1'b0;
    unique case (cur.mode)
      bcd_pkg::MODE_IDLE: begin
        if (v && m && !cur.prev_view && !cur.prev_menu) begin
          nxt.mode = bcd_pkg::MODE_CHORD;
          fired    = 1'b1;
          masked   = btn & ~(vbit | mbit);
        end else if (v && !cur.prev_view) begin
          nxt.mode     = bcd_pkg::MODE_VIEW_WAIT;
          nxt.start_ms = item.now_ms;
          masked       = btn & ~vbit;
        end else if (m && !cur.prev_menu) begin
          nxt.mode     = bcd_pkg::MODE_MENU_WAIT;
          nxt.start_ms = item.now_ms;
          masked       = btn & ~mbit;
        end
      end
      bcd_pkg::MODE_VIEW_WAIT: begin
        if (timed_out || !v) begin
          nxt.mode = bcd_pkg::MODE_IDLE;
          masked   = btn | vbit;
        end else if (m && !cur.prev_menu) begin
          nxt.mode = bcd_pkg::MODE_CHORD;
          fired    = 1'b1;
          masked   = btn & ~(vbit | mbit);
        end else begin
          masked = btn & ~vbit;
        end
      end
      bcd_pkg::MODE_MENU_WAIT: begin
        if (timed_out || !m) begin
          nxt.mode = bcd_pkg::MODE_IDLE;
          masked   = btn | mbit;
        end else if (v && !cur.prev_view) begin
          nxt.mode = bcd_pkg::MODE_CHORD;
          fired    = 1'b1;
          masked   = btn & ~(vbit | mbit);
        end else begin
          masked = btn & ~mbit;
        end
      end
      bcd_pkg::MODE_CHORD: begin
        if (v && m) begin
          masked = btn & ~(vbit | mbit);
        end else begin
          nxt.mode = bcd_pkg::MODE_IDLE;
        end
      end
      default: begin
        nxt.mode = bcd_pkg::MODE_IDLE;
      end
    endcase
    nxt.prev_view = v;
    nxt.prev_menu = m;
  end

  always_comb begin
    res      = '0;
    wb.en    = 1'b0;
    wb.pad   = item.pad_index;
    wb.state = nxt;
    if (in_range) begin
      if (item.opcode == bcd_pkg::OP_RESET) begin
        wb.en    = 1'b1;
        wb.state = '0;
      end else if (item.pad_present) begin
        wb.en              = 1'b1;
        res.chord_fired    = fired;
        res.raw_buttons    = btn;
        res.masked_buttons = masked;
      end
    end
  end

endmodule

`default_nettype wire

/* src/button_chord_detector.sv */
// ---------------------------------------------------------------------------
// button_chord_detector
// Per-pad view/menu chord detector with state held in a small memory.
// ---------------------------------------------------------------------------
// Pipeline: a beat is registered in s1_item_r, its result in out_res_r.
// Throughput: one beat per cycle unless the output stalls; the pad state
// memory is read on accept, written back on advance, with a same-pad bypass.
// Reset: synchronous, active low; all pads return to idle through entry
// valid bits at once, and the registers take their documented reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module button_chord_detector (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // tdata: pad_index[2:0], pad_present[3], buttons[35:4], now_ms[67:36]
  input  wire [bcd_pkg::IN_TDATA_BITS-1:0]      in_tdata,
  // tuser: opcode[0]
  input  wire                                   in_tuser,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // tdata: chord_fired[0], raw_buttons[32:1], masked_buttons[64:33]
  output logic [bcd_pkg::OUT_TDATA_BITS-1:0]    out_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  input  wire                                   cfg_we,
  input  wire [bcd_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  wire [bcd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  bcd_pkg::cfg_t       cfg_r;
  bcd_pkg::item_t      in_item;
  bcd_pkg::item_t      s1_item_r;
  bcd_pkg::pad_state_t rd_state;
  bcd_pkg::result_t    res;
  bcd_pkg::result_t    out_res_r;
  bcd_pkg::wb_t        fsm_wb;
  bcd_pkg::wb_t        mem_wb;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                s1_adv;
  logic                in_fire;

  assign in_item.opcode      = bcd_pkg::opcode_t'(in_tuser);
  assign in_item.pad_index   = in_tdata[2:0];
  assign in_item.pad_present = in_tdata[3];
  assign in_item.buttons     = in_tdata[35:4];
  assign in_item.now_ms      = in_tdata[67:36];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms <= bcd_pkg::TIMEOUT_RESET;
      cfg_r.view_bit   <= bcd_pkg::VIEW_BIT_RESET;
      cfg_r.menu_bit   <= bcd_pkg::MENU_BIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bcd_pkg::CFG_TIMEOUT:  cfg_r.timeout_ms <= cfg_wdata;
        bcd_pkg::CFG_VIEW_BIT: cfg_r.view_bit   <= cfg_wdata[bcd_pkg::BIT_IDX_BITS-1:0];
        bcd_pkg::CFG_MENU_BIT: cfg_r.menu_bit   <= cfg_wdata[bcd_pkg::BIT_IDX_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  bcd_state_mem u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (in_item.pad_index),
    .rd_state (rd_state),
    .wb       (mem_wb)
  );

  bcd_pad_fsm u_pad_fsm (
    .item (s1_item_r),
    .cur  (rd_state),
    .cfg  (cfg_r),
    .res  (res),
    .wb   (fsm_wb)
  );

  always_comb begin
    mem_wb    = fsm_wb;
    mem_wb.en = fsm_wb.en && s1_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.masked_buttons, out_res_r.raw_buttons,
                       out_res_r.chord_fired};

  a_wb_only_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    mem_wb.en |-> s1_adv)
    else $error("pad state written without a beat moving to the output");

  a_fire_enters_chord : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.chord_fired |-> mem_wb.en && mem_wb.state.mode == bcd_pkg::MODE_CHORD)
    else $error("chord fired without the pad entering chord mode");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_tready)
    else $error("input taken while the update stage is stalled");

  a_reset_empties : assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_held_output : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire
